>>> src/gcnc_pkg.sv
// Shared types and constants for the grid cell neighbor counter.
`timescale 1ns / 1ps
`default_nettype none

package gcnc_pkg;

    localparam int POS_W      = 16;
    localparam int SCALE_W    = 24;
    localparam int GSIZE_W    = 6;
    localparam int SUM_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SUM_W-1:0]     SUM_MAX = '1;
    localparam logic [GSIZE_W-1:0]   GRID_SIZE_RST  = 6'd32;
    localparam logic [SCALE_W-1:0]   CELL_SCALE_RST = 24'd8192;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE = 2'd1;

    // Axis select for the shared quantizer multiplier
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load_in;   // capture input word, clear sum
        logic       q_en;      // quantize one axis
        logic [1:0] q_axis;
        logic       scan;      // query read of one neighbor cell
        logic       rd_own;    // insert read of own cell
        logic       inc_wr;    // insert write-back
        logic       clr_en;    // clearing pass write
        logic       load_out;  // move result into output register
        logic [1:0] dx;        // neighbor offsets, 0..2 means -1..+1
        logic [1:0] dy;
        logic [1:0] dz;
    } gcnc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;  // clearing pass at its last cell
        logic out_free;  // output register can take a word this cycle
    } gcnc_sts_t;

endpackage

`default_nettype wire

>>> src/gcnc_ctrl.sv
// Controller state machine for the grid cell neighbor counter.
`timescale 1ns / 1ps
`default_nettype none

module gcnc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              kind,
    input  wire gcnc_pkg::gcnc_sts_t sts,
    output gcnc_pkg::gcnc_cmd_t    cmd
);
    import gcnc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUANT,
        S_RD,
        S_INC,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic       kind_reg;
    logic [1:0] axis_reg;
    logic [1:0] dx_reg;
    logic [1:0] dy_reg;
    logic [1:0] dz_reg;
    logic       accept;
    logic       scan_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign scan_last = (dx_reg == 2'd2) && (dy_reg == 2'd2) && (dz_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= 1'b0;
            axis_reg  <= AXIS_X;
            dx_reg    <= 2'd0;
            dy_reg    <= 2'd0;
            dz_reg    <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clr_done)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        axis_reg  <= AXIS_X;
                        state_reg <= S_QUANT;
                    end
                end
                S_QUANT:
                begin
                    if (axis_reg == AXIS_Z)
                    begin
                        dx_reg    <= 2'd0;
                        dy_reg    <= 2'd0;
                        dz_reg    <= 2'd0;
                        state_reg <= kind_reg ? S_SCAN : S_RD;
                    end
                    else
                        axis_reg <= axis_reg + 2'd1;
                end
                S_RD:
                    state_reg <= S_INC;
                S_INC:
                    state_reg <= S_DONE;
                S_SCAN:
                begin
                    // advance z fastest, then y, then x
                    if (scan_last)
                        state_reg <= S_DRAIN;
                    else if (dz_reg != 2'd2)
                        dz_reg <= dz_reg + 2'd1;
                    else
                    begin
                        dz_reg <= 2'd0;
                        if (dy_reg != 2'd2)
                            dy_reg <= dy_reg + 2'd1;
                        else
                        begin
                            dy_reg <= 2'd0;
                            dx_reg <= dx_reg + 2'd1;
                        end
                    end
                end
                S_DRAIN:
                    state_reg <= S_DONE;
                S_DONE:
                begin
                    if (sts.out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = accept;
        cmd.q_en     = (state_reg == S_QUANT);
        cmd.q_axis   = axis_reg;
        cmd.scan     = (state_reg == S_SCAN);
        cmd.rd_own   = (state_reg == S_RD);
        cmd.inc_wr   = (state_reg == S_INC);
        cmd.clr_en   = (state_reg == S_CLEAR);
        cmd.load_out = (state_reg == S_DONE) && sts.out_free;
        // own cell sits at offset one on every axis
        if (state_reg == S_SCAN)
        begin
            cmd.dx = dx_reg;
            cmd.dy = dy_reg;
            cmd.dz = dz_reg;
        end
        else
        begin
            cmd.dx = 2'd1;
            cmd.dy = 2'd1;
            cmd.dz = 2'd1;
        end
    end

endmodule

`default_nettype wire

>>> src/gcnc_datapath.sv
// Datapath: configuration, quantizer, cell count memory, accumulator, output register.
`timescale 1ns / 1ps
`default_nettype none

module gcnc_datapath #(
    parameter int GRID_MAX    = 32,
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [gcnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcnc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [gcnc_pkg::POS_W-1:0]      pos_x,
    input  wire logic [gcnc_pkg::POS_W-1:0]      pos_y,
    input  wire logic [gcnc_pkg::POS_W-1:0]      pos_z,
    input  wire gcnc_pkg::gcnc_cmd_t             cmd,
    output gcnc_pkg::gcnc_sts_t                  sts,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [gcnc_pkg::SUM_W-1:0]           neighbor_count,
    output logic                                 in_grid
);
    import gcnc_pkg::*;

    localparam int CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_MAX);
    localparam int GSW   = $clog2(GRID_MAX + 1);
    localparam int TW    = POS_W + 1;
    localparam int ADD_W = ((SUM_W > COUNT_WIDTH) ? SUM_W : COUNT_WIDTH) + 1;
    localparam int PW    = POS_W + SCALE_W;

    logic [GSIZE_W-1:0]     grid_size_reg;
    logic [SCALE_W-1:0]     cell_scale_reg;
    logic [POS_W-1:0]       px_reg, py_reg, pz_reg;
    logic [POS_W-1:0]       cx_reg, cy_reg, cz_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   rd_ok_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   out_valid_reg;
    logic [SUM_W-1:0]       out_count_reg;
    logic                   out_grid_reg;

    logic [COUNT_WIDTH-1:0] mem [CELLS];

    logic [GSW-1:0]         gs;
    logic [POS_W-1:0]       coord_sel;
    logic [PW-1:0]          product;
    logic [TW-1:0]          tx, ty, tz, tx1, ty1, tz1;
    logic                   nb_ok;
    logic                   own_in;
    logic [CW-1:0]          nx, ny, nz;
    logic [AW-1:0]          addr;
    logic [ADD_W-1:0]       acc;
    logic [SUM_W-1:0]       acc_sat;
    logic [COUNT_WIDTH-1:0] inc_val;
    logic                   rd_en;

    // Effective size, capped at the grid capacity
    always_comb
    begin
        if (32'(grid_size_reg) > GRID_MAX)
            gs = GSW'(GRID_MAX);
        else
            gs = GSW'(grid_size_reg);
    end

    always_comb
    begin
        unique case (cmd.q_axis)
            AXIS_X:  coord_sel = px_reg;
            AXIS_Y:  coord_sel = py_reg;
            AXIS_Z:  coord_sel = pz_reg;
            default: coord_sel = pz_reg;
        endcase
    end

    assign product = PW'(coord_sel) * PW'(cell_scale_reg);

    // Neighbor coordinate plus one; in range when 1 <= t <= gs
    assign tx  = TW'(cx_reg) + TW'(cmd.dx);
    assign ty  = TW'(cy_reg) + TW'(cmd.dy);
    assign tz  = TW'(cz_reg) + TW'(cmd.dz);
    assign tx1 = tx - TW'(1);
    assign ty1 = ty - TW'(1);
    assign tz1 = tz - TW'(1);
    assign nb_ok = (tx != '0) && (ty != '0) && (tz != '0)
                && (tx <= TW'(gs)) && (ty <= TW'(gs)) && (tz <= TW'(gs));
    assign nx = tx1[CW-1:0];
    assign ny = ty1[CW-1:0];
    assign nz = tz1[CW-1:0];
    assign addr = AW'(nx) * AW'(GRID_MAX * GRID_MAX) + AW'(ny) * AW'(GRID_MAX) + AW'(nz);

    assign own_in = (cx_reg < POS_W'(gs)) && (cy_reg < POS_W'(gs)) && (cz_reg < POS_W'(gs));

    assign rd_en = (cmd.scan || cmd.rd_own) && nb_ok;

    assign acc     = ADD_W'(sum_reg) + ADD_W'(rd_data_reg);
    assign acc_sat = (acc > ADD_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
    assign inc_val = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= GRID_SIZE_RST;
            cell_scale_reg <= CELL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_SIZE)
                grid_size_reg <= cfg_data[GSIZE_W-1:0];
            else if (cfg_index == REG_CELL_SCALE)
                cell_scale_reg <= cfg_data[SCALE_W-1:0];
        end
    end

    // Input capture, quantized cell coordinates and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            sum_reg <= '0;
        end
        else if (rd_ok_reg)
            sum_reg <= acc_sat;
        if (cmd.q_en)
        begin
            unique case (cmd.q_axis)
                AXIS_X:  cx_reg <= product[PW-1:SCALE_W];
                AXIS_Y:  cy_reg <= product[PW-1:SCALE_W];
                AXIS_Z:  cz_reg <= product[PW-1:SCALE_W];
                default: cz_reg <= product[PW-1:SCALE_W];
            endcase
        end
    end

    // Control flags: read-valid pipe, clearing pass, output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= cmd.scan && nb_ok;
            if (cmd.clr_en && !sts.clr_done)
                clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_count_reg <= sum_reg;
            out_grid_reg  <= own_in;
        end
    end

    // Cell count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
            mem[clr_addr_reg] <= '0;
        else if (cmd.inc_wr && nb_ok)
            mem[addr] <= inc_val;
        if (rd_en)
            rd_data_reg <= mem[addr];
    end

    assign sts.clr_done = (clr_addr_reg == AW'(CELLS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign neighbor_count = out_count_reg;
    assign in_grid        = out_grid_reg;

endmodule

`default_nettype wire

>>> src/grid_cell_neighbor_counter.sv
// Top level of the uniform 3D grid cell neighbor counter.
// Query: quantize three axes, 27 neighbor reads on the single memory read port,
// drain, result. Insert: quantize, read-modify-write of own cell, result. A new
// word is taken only once the last result is in the output register.
// After reset a clearing pass writes all GRID_MAX^3 cells (32768 by default),
// with input held off; configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none

module grid_cell_neighbor_counter #(
    parameter int GRID_MAX    = 32,
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gcnc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcnc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [gcnc_pkg::POS_W-1:0]      pos_x,
    input  wire logic [gcnc_pkg::POS_W-1:0]      pos_y,
    input  wire logic [gcnc_pkg::POS_W-1:0]      pos_z,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [gcnc_pkg::SUM_W-1:0]           neighbor_count,
    output logic                                 in_grid
);
    import gcnc_pkg::*;

    gcnc_cmd_t cmd;
    gcnc_sts_t sts;

    assign cfg_ready = 1'b1;

    gcnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .sts      (sts),
        .cmd      (cmd)
    );

    gcnc_datapath #(
        .GRID_MAX    (GRID_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .neighbor_count (neighbor_count),
        .in_grid        (in_grid)
    );

endmodule

`default_nettype wire
